// File: rtl/core/wobn_pkg.sv
`default_nettype none
package wobn_pkg;

    localparam int RING_DEPTH_DEF = 1024;
    localparam int ID_BITS_DEF    = 16;
    localparam int NODE_ID_W      = 16;
    localparam int SRC_W          = 16;
    localparam int LEN_W          = 24;
    localparam int BYTE_W         = 8;
    localparam int EXT_W          = 32;

endpackage
`default_nettype wire

// File: rtl/core/wobn_ram.sv
`default_nettype none
module wobn_ram #(
    parameter int DATA_W = wobn_pkg::BYTE_W,
    parameter int DEPTH  = wobn_pkg::RING_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// File: rtl/core/wobn_skid.sv
`default_nettype none
module wobn_skid #(
    parameter int DATA_W = wobn_pkg::BYTE_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [DATA_W-1:0] o_data
);

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_skid_valid;
    logic [DATA_W-1:0] r_skid_data;
    logic              w_acc;

    assign o_ready = !r_skid_valid;
    assign w_acc   = i_valid && !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            // output slot frees up: skid word first, else the new word
            r_out_valid  <= r_skid_valid || w_acc;
            r_skid_valid <= 1'b0;
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (w_acc) begin
                r_out_data <= i_data;
            end
        end else if (w_acc) begin
            r_skid_valid <= 1'b1;
            r_skid_data  <= i_data;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/wired_or_bus_arbitrating_node.sv
// wired-or bus node with bitwise id arbitration, 1 dominant
// input channel (i_valid / o_ready): one word per bus bit slot (i_kind = 0,
// i_bus_level sampled) or one byte appended to the send ring (i_kind = 1)
// output channel (o_valid / i_ready): exactly one result word per input word,
// in order: drive level for the slot, received byte, frame end, source id,
// length, send done, arbitration loss, ring fill, append reject, busy
// config channel (i_cfg_valid / o_cfg_ready): writes the own node id; always
// ready, to be written only while the node is idle
// latency: the result word is valid the cycle after its input word is taken, if the output slot is free
// throughput: one word per cycle while o_ready is high; each slot is handled by one
// registered pass of the frame sequencer, the send ring read is prefetched at the
// next-state address so the data bit is ready whenever the next slot comes
// receiver stall: results wait in a two-word output buffer; o_ready drops
// only when both words are held
// reset: idle, send ring empty, node id 0; no clearing pass is needed
`default_nettype none
module wired_or_bus_arbitrating_node #(
    parameter int RING_DEPTH = wobn_pkg::RING_DEPTH_DEF,
    parameter int ID_BITS    = wobn_pkg::ID_BITS_DEF,
    parameter int CNT_W      = $clog2(RING_DEPTH + 1)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [wobn_pkg::NODE_ID_W-1:0] i_cfg_node_id,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_kind,
    input  wire logic                           i_bus_level,
    input  wire logic [wobn_pkg::BYTE_W-1:0]    i_tx_byte,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_drive_bit,
    output logic                                o_rx_valid,
    output logic      [wobn_pkg::BYTE_W-1:0]    o_rx_byte,
    output logic                                o_rx_frame_end,
    output logic      [wobn_pkg::SRC_W-1:0]     o_rx_source,
    output logic      [wobn_pkg::LEN_W-1:0]     o_rx_length,
    output logic                                o_tx_done,
    output logic                                o_lost_arbitration,
    output logic      [CNT_W-1:0]               o_tx_count,
    output logic                                o_load_rejected,
    output logic                                o_busy_res
);

    import wobn_pkg::*;

    localparam int PTR_W   = $clog2(RING_DEPTH);
    localparam int SUM_W   = PTR_W + 1;
    localparam int MAX_B   = (ID_BITS > LEN_W) ? ID_BITS : LEN_W;
    localparam int POS_W   = $clog2(MAX_B);
    localparam int IDX_W   = $clog2(ID_BITS);
    localparam int BIDX_W  = $clog2(BYTE_W);
    localparam int RES_W   = 1 + 1 + BYTE_W + 1 + SRC_W + LEN_W + 1 + 1 + CNT_W + 1 + 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ARB,
        PH_TXLEN,
        PH_TXDATA,
        PH_RXID,
        PH_RXLEN,
        PH_RXDATA
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [ID_BITS-1:0]    r_src, n_src;
    logic [LEN_W-1:0]      r_len, n_len;
    logic [BYTE_W-1:0]     r_byte, n_byte;
    logic [LEN_W-1:0]      r_left, n_left;
    logic [PTR_W-1:0]      r_head, n_head;
    logic [CNT_W-1:0]      r_fill, n_fill;
    logic [CNT_W-1:0]      r_flen, n_flen;
    logic [PTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [NODE_ID_W-1:0]  r_node_id;

    logic                  w_acc;
    logic [EXT_W-1:0]      w_id_ext;
    logic [ID_BITS-1:0]    w_own_id;
    logic [EXT_W-1:0]      w_src_ext;
    logic [SUM_W-1:0]      w_wsum;
    logic [PTR_W-1:0]      w_waddr;
    logic                  w_wr_en;
    logic [PTR_W-1:0]      w_ptr_inc;
    logic [LEN_W-1:0]      w_flen_ext;
    logic [BYTE_W-1:0]     w_ram_q;
    logic                  w_in_ready;
    logic [RES_W-1:0]      w_res;
    logic [RES_W-1:0]      w_out_data;

    logic                  w_drive, w_rxv, w_fend, w_done, w_lost, w_rej;
    logic [BYTE_W-1:0]     w_rxb;
    logic [SRC_W-1:0]      w_rsrc;
    logic [LEN_W-1:0]      w_rlen;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = w_in_ready;
    assign w_acc       = i_valid && w_in_ready;

    assign w_id_ext   = EXT_W'(r_node_id);
    assign w_own_id   = w_id_ext[ID_BITS-1:0];
    assign w_flen_ext = LEN_W'(r_flen);

    // ring write slot: head + fill, wrapped
    assign w_wsum  = SUM_W'(r_head) + SUM_W'(r_fill);
    assign w_waddr = (w_wsum >= SUM_W'(RING_DEPTH)) ? PTR_W'(w_wsum - SUM_W'(RING_DEPTH))
                                                     : PTR_W'(w_wsum);
    assign w_wr_en = w_acc && i_kind && (r_fill < CNT_W'(RING_DEPTH));

    assign w_ptr_inc = (r_rd_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_src    = r_src;
        n_len    = r_len;
        n_byte   = r_byte;
        n_left   = r_left;
        n_head   = r_head;
        n_fill   = r_fill;
        n_flen   = r_flen;
        n_rd_ptr = r_rd_ptr;
        w_drive  = 1'b0;
        w_rxv    = 1'b0;
        w_rxb    = '0;
        w_fend   = 1'b0;
        w_done   = 1'b0;
        w_lost   = 1'b0;
        w_rej    = 1'b0;
        if (w_acc) begin
            if (i_kind) begin
                if (w_wr_en) begin
                    n_fill = r_fill + CNT_W'(1);
                end else begin
                    w_rej = 1'b1;
                end
            end else begin
                unique case (r_phase)
                    PH_ARB: begin
                        w_drive = w_own_id[r_pos[IDX_W-1:0]];
                        n_src[r_pos[IDX_W-1:0]] = i_bus_level;
                        if (i_bus_level && !w_own_id[r_pos[IDX_W-1:0]]) begin
                            w_lost = 1'b1;
                            if (r_pos == '0) begin
                                n_phase = PH_RXLEN;
                                n_pos   = POS_W'(LEN_W - 1);
                                n_len   = '0;
                            end else begin
                                n_phase = PH_RXID;
                                n_pos   = r_pos - POS_W'(1);
                            end
                        end else if (r_pos == '0) begin
                            n_phase = PH_TXLEN;
                            n_pos   = POS_W'(LEN_W - 1);
                        end else begin
                            n_pos = r_pos - POS_W'(1);
                        end
                    end
                    PH_TXLEN: begin
                        w_drive = w_flen_ext[r_pos];
                        if (r_pos == '0) begin
                            if (r_flen == '0) begin
                                w_done  = 1'b1;
                                n_phase = PH_IDLE;
                            end else begin
                                n_left  = w_flen_ext;
                                n_pos   = POS_W'(BYTE_W - 1);
                                n_phase = PH_TXDATA;
                            end
                        end else begin
                            n_pos = r_pos - POS_W'(1);
                        end
                    end
                    PH_TXDATA: begin
                        w_drive = w_ram_q[r_pos[BIDX_W-1:0]];
                        if (r_pos == '0) begin
                            n_left = r_left - LEN_W'(1);
                            if (n_left == '0) begin
                                w_done   = 1'b1;
                                n_head   = w_ptr_inc;
                                n_rd_ptr = w_ptr_inc;
                                n_fill   = r_fill - r_flen;
                                n_flen   = '0;
                                n_phase  = PH_IDLE;
                            end else begin
                                n_rd_ptr = w_ptr_inc;
                                n_pos    = POS_W'(BYTE_W - 1);
                            end
                        end else begin
                            n_pos = r_pos - POS_W'(1);
                        end
                    end
                    PH_RXID: begin
                        n_src[r_pos[IDX_W-1:0]] = i_bus_level;
                        if (r_pos == '0) begin
                            n_phase = PH_RXLEN;
                            n_pos   = POS_W'(LEN_W - 1);
                            n_len   = '0;
                        end else begin
                            n_pos = r_pos - POS_W'(1);
                        end
                    end
                    PH_RXLEN: begin
                        n_len[r_pos] = i_bus_level;
                        if (r_pos == '0) begin
                            if (n_len == '0) begin
                                w_fend  = 1'b1;
                                n_phase = PH_IDLE;
                            end else begin
                                n_left  = n_len;
                                n_byte  = '0;
                                n_pos   = POS_W'(BYTE_W - 1);
                                n_phase = PH_RXDATA;
                            end
                        end else begin
                            n_pos = r_pos - POS_W'(1);
                        end
                    end
                    PH_RXDATA: begin
                        n_byte[r_pos[BIDX_W-1:0]] = i_bus_level;
                        if (r_pos == '0) begin
                            w_rxv  = 1'b1;
                            w_rxb  = n_byte;
                            n_byte = '0;
                            n_left = r_left - LEN_W'(1);
                            if (n_left == '0) begin
                                w_fend  = 1'b1;
                                n_phase = PH_IDLE;
                            end else begin
                                n_pos = POS_W'(BYTE_W - 1);
                            end
                        end else begin
                            n_pos = r_pos - POS_W'(1);
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        if (r_fill != '0) begin
                            w_drive  = 1'b1;
                            n_flen   = r_fill;
                            n_src    = '0;
                            n_pos    = POS_W'(ID_BITS - 1);
                            n_rd_ptr = r_head;
                            n_phase  = PH_ARB;
                        end else if (i_bus_level) begin
                            n_src   = '0;
                            n_pos   = POS_W'(ID_BITS - 1);
                            n_phase = PH_RXID;
                        end
                    end
                endcase
            end
        end
    end

    assign w_src_ext = EXT_W'(n_src);
    assign w_rsrc    = (w_rxv || w_fend) ? w_src_ext[SRC_W-1:0] : '0;
    assign w_rlen    = (w_rxv || w_fend) ? n_len : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pos     <= '0;
            r_src     <= '0;
            r_len     <= '0;
            r_byte    <= '0;
            r_left    <= '0;
            r_head    <= '0;
            r_fill    <= '0;
            r_flen    <= '0;
            r_rd_ptr  <= '0;
            r_node_id <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_src    <= n_src;
            r_len    <= n_len;
            r_byte   <= n_byte;
            r_left   <= n_left;
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_flen   <= n_flen;
            r_rd_ptr <= n_rd_ptr;
            if (i_cfg_valid) begin
                r_node_id <= i_cfg_node_id;
            end
        end
    end

    // read address follows the next state, so the data matches the next slot
    wobn_ram #(
        .DATA_W (BYTE_W),
        .DEPTH  (RING_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_waddr),
        .i_wr_data (i_tx_byte),
        .i_rd_addr (n_rd_ptr),
        .o_rd_data (w_ram_q)
    );

    assign w_res = {w_drive, w_rxv, w_rxb, w_fend, w_rsrc, w_rlen, w_done, w_lost,
                    n_fill, w_rej, (n_phase != PH_IDLE)};

    wobn_skid #(
        .DATA_W (RES_W)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (w_in_ready),
        .i_data  (w_res),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_out_data)
    );

    assign {o_drive_bit, o_rx_valid, o_rx_byte, o_rx_frame_end, o_rx_source, o_rx_length,
            o_tx_done, o_lost_arbitration, o_tx_count, o_load_rejected, o_busy_res} = w_out_data;

endmodule
`default_nettype wire

// File: tb/wobn_checker.sv
`timescale 1ns / 100ps
module wobn_checker #(
    parameter int RING_DEPTH = wobn_pkg::RING_DEPTH_DEF,
    parameter int CNT_W      = $clog2(RING_DEPTH + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [wobn_pkg::NODE_ID_W-1:0] i_cfg_node_id,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_kind,
    input  logic                           i_bus_level,
    input  logic [wobn_pkg::BYTE_W-1:0]    i_tx_byte,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic                           i_drive_bit,
    input  logic                           i_rx_valid,
    input  logic [wobn_pkg::BYTE_W-1:0]    i_rx_byte,
    input  logic                           i_rx_frame_end,
    input  logic [wobn_pkg::SRC_W-1:0]     i_rx_source,
    input  logic [wobn_pkg::LEN_W-1:0]     i_rx_length,
    input  logic                           i_tx_done,
    input  logic                           i_lost_arbitration,
    input  logic [CNT_W-1:0]               i_tx_count,
    input  logic                           i_load_rejected,
    input  logic                           i_busy_res,
    output int                             o_pending,
    output int                             o_mismatches,
    output logic [CNT_W-1:0]               o_ring_fill
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_ARB, ST_TXLEN, ST_TXDATA, ST_RXID, ST_RXLEN, ST_RXDATA
    } node_state_e;

    typedef struct packed {
        logic                           drive;
        logic                           rx_valid;
        logic [wobn_pkg::BYTE_W-1:0]    rx_byte;
        logic                           frame_end;
        logic [wobn_pkg::SRC_W-1:0]     source;
        logic [wobn_pkg::LEN_W-1:0]     length;
        logic                           tx_done;
        logic                           lost;
        logic [CNT_W-1:0]               count;
        logic                           rejected;
        logic                           busy;
    } slot_result_t;

    node_state_e                  state;
    logic [4:0]                   bit_pos;
    logic [wobn_pkg::SRC_W-1:0]   src_sh;
    logic [wobn_pkg::LEN_W-1:0]   len_sh;
    logic [wobn_pkg::BYTE_W-1:0]  byte_sh;
    logic [wobn_pkg::LEN_W-1:0]   bytes_left;
    logic [wobn_pkg::BYTE_W-1:0]  tx_ring [RING_DEPTH];
    logic [9:0]                   head;
    logic [CNT_W-1:0]             fill;
    logic [CNT_W-1:0]             frame_len;
    logic [wobn_pkg::NODE_ID_W-1:0] own_id;

    slot_result_t slot_results_q[$];
    int           mismatch_cnt;

    initial begin
        o_pending    = 0;
        o_mismatches = 0;
        o_ring_fill  = '0;
    end

    task automatic predict_slot(input logic kind, input logic lvl,
                                input logic [7:0] txb, output slot_result_t r);
        logic        mine;
        logic [9:0]  idx;
        logic [23:0] flen24;
        logic [23:0] offs;
        r = '0;
        flen24 = {13'd0, frame_len};
        if (kind) begin
            if (fill >= RING_DEPTH) begin
                r.rejected = 1'b1;
            end else begin
                idx = head + fill[9:0];
                tx_ring[idx] = txb;
                fill = fill + 1'b1;
            end
        end else begin
            case (state)
                ST_ARB: begin
                    mine = own_id[bit_pos[3:0]];
                    r.drive = mine;
                    if (lvl) src_sh[bit_pos[3:0]] = 1'b1;
                    if (lvl && !mine) begin
                        r.lost = 1'b1;
                        if (bit_pos == 0) begin
                            state = ST_RXLEN;
                            bit_pos = 5'd23;
                            len_sh = '0;
                        end else begin
                            state = ST_RXID;
                            bit_pos = bit_pos - 1'b1;
                        end
                    end else if (bit_pos == 0) begin
                        state = ST_TXLEN;
                        bit_pos = 5'd23;
                    end else begin
                        bit_pos = bit_pos - 1'b1;
                    end
                end
                ST_TXLEN: begin
                    r.drive = flen24[bit_pos];
                    if (bit_pos == 0) begin
                        if (frame_len == 0) begin
                            r.tx_done = 1'b1;
                            state = ST_IDLE;
                        end else begin
                            bytes_left = flen24;
                            bit_pos = 5'd7;
                            state = ST_TXDATA;
                        end
                    end else begin
                        bit_pos = bit_pos - 1'b1;
                    end
                end
                ST_TXDATA: begin
                    offs = flen24 - bytes_left;
                    idx = head + offs[9:0];
                    r.drive = tx_ring[idx][bit_pos[2:0]];
                    if (bit_pos == 0) begin
                        bytes_left = bytes_left - 1'b1;
                        if (bytes_left == 0) begin
                            r.tx_done = 1'b1;
                            head = head + frame_len[9:0];
                            fill = fill - frame_len;
                            frame_len = '0;
                            state = ST_IDLE;
                        end else begin
                            bit_pos = 5'd7;
                        end
                    end else begin
                        bit_pos = bit_pos - 1'b1;
                    end
                end
                ST_RXID: begin
                    if (lvl) src_sh[bit_pos[3:0]] = 1'b1;
                    if (bit_pos == 0) begin
                        state = ST_RXLEN;
                        bit_pos = 5'd23;
                        len_sh = '0;
                    end else begin
                        bit_pos = bit_pos - 1'b1;
                    end
                end
                ST_RXLEN: begin
                    if (lvl) len_sh[bit_pos] = 1'b1;
                    if (bit_pos == 0) begin
                        if (len_sh == 0) begin
                            r.frame_end = 1'b1;
                            state = ST_IDLE;
                        end else begin
                            bytes_left = len_sh;
                            byte_sh = '0;
                            bit_pos = 5'd7;
                            state = ST_RXDATA;
                        end
                    end else begin
                        bit_pos = bit_pos - 1'b1;
                    end
                end
                ST_RXDATA: begin
                    if (lvl) byte_sh[bit_pos[2:0]] = 1'b1;
                    if (bit_pos == 0) begin
                        r.rx_valid = 1'b1;
                        r.rx_byte = byte_sh;
                        byte_sh = '0;
                        bytes_left = bytes_left - 1'b1;
                        if (bytes_left == 0) begin
                            r.frame_end = 1'b1;
                            state = ST_IDLE;
                        end else begin
                            bit_pos = 5'd7;
                        end
                    end else begin
                        bit_pos = bit_pos - 1'b1;
                    end
                end
                default: begin
                    state = ST_IDLE;
                    if (fill > 0) begin
                        r.drive = 1'b1;
                        frame_len = fill;
                        src_sh = '0;
                        bit_pos = 5'd15;
                        state = ST_ARB;
                    end else if (lvl) begin
                        src_sh = '0;
                        bit_pos = 5'd15;
                        state = ST_RXID;
                    end
                end
            endcase
        end
        if (r.rx_valid || r.frame_end) begin
            r.source = src_sh;
            r.length = len_sh;
        end
        r.count = fill;
        r.busy = (state != ST_IDLE);
    endtask

    function automatic string fmt_result(slot_result_t r);
        return $sformatf({"drv=%0b rxv=%0b byte=%02h end=%0b src=%04h len=%06h",
                          " done=%0b lost=%0b cnt=%0d rej=%0b busy=%0b"},
                         r.drive, r.rx_valid, r.rx_byte, r.frame_end, r.source,
                         r.length, r.tx_done, r.lost, r.count, r.rejected, r.busy);
    endfunction

    always @(posedge i_clk) begin
        slot_result_t exp_word;
        slot_result_t act_word;
        if (!i_rst_n) begin
            state = ST_IDLE;
            bit_pos = '0;
            src_sh = '0;
            len_sh = '0;
            byte_sh = '0;
            bytes_left = '0;
            head = '0;
            fill = '0;
            frame_len = '0;
            own_id = '0;
            slot_results_q.delete();
            mismatch_cnt = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) own_id = i_cfg_node_id;
            if (i_out_valid && i_out_ready) begin
                act_word = {i_drive_bit, i_rx_valid, i_rx_byte, i_rx_frame_end,
                            i_rx_source, i_rx_length, i_tx_done, i_lost_arbitration,
                            i_tx_count, i_load_rejected, i_busy_res};
                if (slot_results_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: result word with none expected: %s",
                                 $realtime, fmt_result(act_word));
                end else begin
                    exp_word = slot_results_q.pop_front();
                    if (act_word !== exp_word) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("%0t: mismatch exp %s", $realtime, fmt_result(exp_word));
                            $display("%0t:          act %s", $realtime, fmt_result(act_word));
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_slot(i_kind, i_bus_level, i_tx_byte, exp_word);
                slot_results_q.push_back(exp_word);
            end
        end
        o_pending    <= slot_results_q.size();
        o_mismatches <= mismatch_cnt;
        o_ring_fill  <= fill;
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
module tb;

    localparam int CNT_W       = $clog2(wobn_pkg::RING_DEPTH_DEF + 1);
    localparam int RING_DEPTH  = wobn_pkg::RING_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int ITEM_GOAL   = 600;

    // bus patterns during arbitration
    localparam int BUS_MAX   = 0;
    localparam int BUS_OR    = 1;
    localparam int BUS_NOISE = 2;
    localparam int BUS_ALONE = 3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_node_id = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        in_kind = 1'b0;
    logic        in_lvl = 1'b0;
    logic [7:0]  in_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        drive_bit;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        rx_frame_end;
    logic [15:0] rx_source;
    logic [23:0] rx_length;
    logic        tx_done;
    logic        lost_arb;
    logic [CNT_W-1:0] tx_count;
    logic        load_rejected;
    logic        busy_res;

    int               pending;
    int               mismatches;
    logic [CNT_W-1:0] ring_fill_seen;

    int          item_cnt = 0;
    int          cycle_cnt;
    bit          no_gaps = 1'b0;
    bit          loads_off = 1'b1;
    logic [15:0] node_id_sel = '0;

    wired_or_bus_arbitrating_node u_top (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_node_id      (cfg_node_id),
        .i_valid            (in_valid),
        .o_ready            (in_ready),
        .i_kind             (in_kind),
        .i_bus_level        (in_lvl),
        .i_tx_byte          (in_byte),
        .o_valid            (out_valid),
        .i_ready            (out_ready),
        .o_drive_bit        (drive_bit),
        .o_rx_valid         (rx_valid),
        .o_rx_byte          (rx_byte),
        .o_rx_frame_end     (rx_frame_end),
        .o_rx_source        (rx_source),
        .o_rx_length        (rx_length),
        .o_tx_done          (tx_done),
        .o_lost_arbitration (lost_arb),
        .o_tx_count         (tx_count),
        .o_load_rejected    (load_rejected),
        .o_busy_res         (busy_res)
    );

    wobn_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_node_id      (cfg_node_id),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_kind             (in_kind),
        .i_bus_level        (in_lvl),
        .i_tx_byte          (in_byte),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_drive_bit        (drive_bit),
        .i_rx_valid         (rx_valid),
        .i_rx_byte          (rx_byte),
        .i_rx_frame_end     (rx_frame_end),
        .i_rx_source        (rx_source),
        .i_rx_length        (rx_length),
        .i_tx_done          (tx_done),
        .i_lost_arbitration (lost_arb),
        .i_tx_count         (tx_count),
        .i_load_rejected    (load_rejected),
        .i_busy_res         (busy_res),
        .o_pending          (pending),
        .o_mismatches       (mismatches),
        .o_ring_fill        (ring_fill_seen)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("simulation failed");
        $finish;
    end

    // receiver stalls
    initial begin
        int run;
        int stall;
        @(posedge clk);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
            if ($urandom_range(0, 9) < 7)
                stall = $urandom_range(1, 3);
            else if ($urandom_range(0, 2) == 0)
                stall = $urandom_range(15, 40);
            else
                stall = 0;
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] pick_rival();
        case ($urandom_range(0, 5))
            0: return node_id_sel;
            1: return node_id_sel ^ 16'h0001;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_len();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
    endfunction

    task automatic send_word(input logic kind, input logic lvl, input logic [7:0] b,
                             input bit counted);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_kind  <= kind;
        in_lvl   <= lvl;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (counted) item_cnt++;
    endtask

    task automatic append_byte(input logic [7:0] b);
        send_word(1'b1, 1'($urandom), b, 1'b1);
    endtask

    // one bus slot inside a frame, now and then preceded by an append
    task automatic frame_slot(input logic lvl);
        if (!loads_off && $urandom_range(0, 19) == 0) append_byte(8'($urandom));
        send_word(1'b0, lvl, 8'($urandom), 1'b1);
    endtask

    task automatic send_field(input logic [23:0] v, input int nbits);
        for (int i = nbits - 1; i >= 0; i--) frame_slot(v[i]);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_node_id(input logic [15:0] v);
        cfg_valid   <= 1'b1;
        cfg_node_id <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid   <= 1'b0;
        node_id_sel = v;
        @(posedge clk);
    endtask

    // a frame from another node heard while idle with nothing to send
    task automatic listen_frame(input logic [15:0] src, input int len);
        send_word(1'b0, 1'b1, 8'($urandom), 1'b1);
        send_field(24'(src), 16);
        send_field(24'(len), 24);
        repeat (len) send_field(24'($urandom_range(0, 255)), 8);
    endtask

    // own frame pending: start, arbitration, then either own frame or rival frame
    task automatic own_frame(input int mode, input logic [15:0] rival);
        logic [15:0] bus_id;
        int          flen;
        int          rlen;
        bit          lost;
        flen = int'(ring_fill_seen);
        case (mode)
            BUS_MAX:   bus_id = (node_id_sel > rival) ? node_id_sel : rival;
            BUS_OR:    bus_id = node_id_sel | rival;
            BUS_NOISE: bus_id = 16'($urandom);
            default:   bus_id = node_id_sel;
        endcase
        lost = |(~node_id_sel & bus_id);
        send_word(1'b0, 1'($urandom), 8'($urandom), 1'b1);
        send_field(24'(bus_id), 16);
        if (lost) begin
            rlen = pick_len();
            send_field(24'(rlen), 24);
            repeat (rlen) send_field(24'($urandom_range(0, 255)), 8);
        end else begin
            repeat (24 + 8 * flen) frame_slot(1'($urandom));
        end
    endtask

    task automatic load_bytes(input int n);
        repeat (n) append_byte(8'($urandom));
    endtask

    initial begin
        logic [15:0] new_id;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_word(1'b0, 1'b0, 8'h5A, 1'b0);
        send_word(1'b1, 1'b1, 8'hFF, 1'b1);
        drain_results();
        own_frame(BUS_MAX, 16'h0001);
        drain_results();
        write_node_id(16'hFFFF);
        own_frame(BUS_MAX, 16'h0000);
        drain_results();
        listen_frame(16'hA5C3, 0);
        drain_results();
        listen_frame(16'hFFFF, 1);
        drain_results();
        send_word(1'b1, 1'b0, 8'h00, 1'b1);
        drain_results();
        own_frame(BUS_OR, 16'hFFFF);

        // random
        loads_off = 1'b0;
        while (item_cnt < ITEM_GOAL) begin
            drain_results();
            if ($urandom_range(0, 3) == 0) begin
                repeat (2) @(posedge clk);
                case ($urandom_range(0, 3))
                    0: new_id = 16'h0000;
                    1: new_id = 16'hFFFF;
                    default: new_id = 16'($urandom);
                endcase
                write_node_id(new_id);
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            if (ring_fill_seen == 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: listen_frame(16'($urandom), pick_len());
                    4, 5, 6: load_bytes($urandom_range(1, 4));
                    7: load_bytes($urandom_range(5, 16));
                    default: begin
                        repeat ($urandom_range(1, 4)) send_word(1'b0, 1'b0, 8'($urandom), 1'b0);
                        load_bytes($urandom_range(1, 3));
                    end
                endcase
            end else begin
                own_frame(int'($urandom_range(BUS_MAX, BUS_ALONE)), pick_rival());
            end
        end

        // full send ring: overfill, then send the whole ring as one frame
        drain_results();
        no_gaps = 1'b0;
        load_bytes(RING_DEPTH - int'(ring_fill_seen) + 2);
        drain_results();
        write_node_id(16'hFFFF);
        own_frame(BUS_MAX, pick_rival());

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
